[rtl/core/asst_pkg.sv]
// Shared types, codes and the micro-program of the anchor self-survey block.
// Used by the sequencer and the square root unit; depends on nothing.
package asst_pkg;

	localparam int DIST_W = 32;
	localparam int ACC_W  = 64;

	// Anchor kinds that are computed.
	localparam logic [7:0] KIND_A1 = 8'd1;
	localparam logic [7:0] KIND_A2 = 8'd2;
	localparam logic [7:0] KIND_A3 = 8'd3;

	// Micro-operations.
	localparam logic [2:0] OP_MUL  = 3'd0;
	localparam logic [2:0] OP_DIVX = 3'd1;
	localparam logic [2:0] OP_DIVY = 3'd2;
	localparam logic [2:0] OP_ROOT = 3'd3;
	localparam logic [2:0] OP_END  = 3'd4;

	// Multiplier operand selects.
	localparam logic [2:0] SEL_R0 = 3'd0;
	localparam logic [2:0] SEL_R1 = 3'd1;
	localparam logic [2:0] SEL_R2 = 3'd2;
	localparam logic [2:0] SEL_X  = 3'd3;
	localparam logic [2:0] SEL_Y  = 3'd4;
	localparam logic [2:0] SEL_X1 = 3'd5;
	localparam logic [2:0] SEL_X2 = 3'd6;
	localparam logic [2:0] SEL_Y2 = 3'd7;

	// Accumulation weights, three bit two's complement.
	localparam logic [2:0] C_ZERO = 3'b000;
	localparam logic [2:0] C_P1   = 3'b001;
	localparam logic [2:0] C_P2   = 3'b010;
	localparam logic [2:0] C_M1   = 3'b111;
	localparam logic [2:0] C_M2   = 3'b110;
	localparam logic [2:0] C_M3   = 3'b101;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] sel_a;
		logic [2:0] sel_b;
		logic [2:0] coef_n;
		logic [2:0] coef_s;
	} uop_t;

	// Request to the square root unit.
	typedef struct packed {
		logic start;
		logic third;
	} root_req_t;

	function automatic uop_t mk(logic [2:0] op, logic [2:0] a, logic [2:0] b,
			logic [2:0] cn, logic [2:0] cs);
		uop_t u;
		u.op = op;
		u.sel_a = a;
		u.sel_b = b;
		u.coef_n = cn;
		u.coef_s = cs;
		return u;
	endfunction

	// Program for anchor 2 (k3 low) and anchor 3 (k3 high).
	function automatic uop_t prog(logic k3, logic [3:0] step);
		uop_t u;
		u = mk(OP_END, SEL_R0, SEL_R0, C_ZERO, C_ZERO);
		if (!k3) begin
			unique case (step)
				4'd0: u = mk(OP_MUL, SEL_R1, SEL_R1, C_P1, C_P1);
				4'd1: u = mk(OP_MUL, SEL_R0, SEL_R0, C_M1, C_P1);
				4'd2: u = mk(OP_DIVX, SEL_R0, SEL_R0, C_ZERO, C_ZERO);
				4'd3: u = mk(OP_MUL, SEL_X, SEL_X, C_ZERO, C_M2);
				4'd4: u = mk(OP_MUL, SEL_X, SEL_X1, C_ZERO, C_P2);
				4'd5: u = mk(OP_MUL, SEL_X1, SEL_X1, C_ZERO, C_M1);
				4'd6: u = mk(OP_ROOT, SEL_R0, SEL_R0, C_ZERO, C_ZERO);
				default: u = mk(OP_END, SEL_R0, SEL_R0, C_ZERO, C_ZERO);
			endcase
		end else begin
			unique case (step)
				4'd0: u = mk(OP_MUL, SEL_R1, SEL_R1, C_P1, C_P1);
				4'd1: u = mk(OP_MUL, SEL_R0, SEL_R0, C_M1, C_P1);
				4'd2: u = mk(OP_MUL, SEL_X1, SEL_X1, C_M1, C_M1);
				4'd3: u = mk(OP_DIVX, SEL_R0, SEL_R0, C_ZERO, C_ZERO);
				4'd4: u = mk(OP_MUL, SEL_R2, SEL_R2, C_P1, C_P1);
				4'd5: u = mk(OP_MUL, SEL_R0, SEL_R0, C_M1, C_ZERO);
				4'd6: u = mk(OP_MUL, SEL_Y2, SEL_Y2, C_M1, C_M1);
				4'd7: u = mk(OP_MUL, SEL_X2, SEL_X2, C_M1, C_M1);
				4'd8: u = mk(OP_MUL, SEL_X2, SEL_X, C_P2, C_P2);
				4'd9: u = mk(OP_DIVY, SEL_R0, SEL_R0, C_ZERO, C_ZERO);
				4'd10: u = mk(OP_MUL, SEL_X1, SEL_X, C_ZERO, C_P2);
				4'd11: u = mk(OP_MUL, SEL_Y2, SEL_Y, C_ZERO, C_P2);
				4'd12: u = mk(OP_MUL, SEL_X, SEL_X, C_ZERO, C_M3);
				4'd13: u = mk(OP_MUL, SEL_Y, SEL_Y, C_ZERO, C_M3);
				4'd14: u = mk(OP_ROOT, SEL_R0, SEL_R0, C_ZERO, C_ZERO);
				default: u = mk(OP_END, SEL_R0, SEL_R0, C_ZERO, C_ZERO);
			endcase
		end
		return u;
	endfunction

	// Weight a product by a small signed constant.
	function automatic logic signed [ACC_W-1:0] scale(logic signed [ACC_W-1:0] v,
			logic [2:0] c);
		logic signed [ACC_W-1:0] r;
		unique case (c)
			C_P1: r = v;
			C_P2: r = v <<< 1;
			C_M1: r = -v;
			C_M2: r = -(v <<< 1);
			C_M3: r = -(v + (v <<< 1));
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/asst_mul.sv]
// Bit-serial signed 32 x 32 multiplier with a fixed-point scale at the end.
// One multiplier bit per cycle; no package dependency.
module asst_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               done,
	output logic signed [63:0] prod
);

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic signed [63:0] mcand_q, acc_q, prod_q, addend, acc_nxt;
	logic [31:0] mplier_q;

	// The top multiplier bit carries negative weight.
	always_comb begin
		addend = '0;
		if (mplier_q[0]) begin
			addend = (cnt_q == 5'd31) ? -mcand_q : mcand_q;
		end
		acc_nxt = acc_q + addend;
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift registers and accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= 64'(a);
			mplier_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
			if (cnt_q == 5'd31) begin
				prod_q <= acc_nxt >>> FRAC_BITS;
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

[rtl/core/asst_div.sv]
// Restoring fixed-point divider: num * 2^F / den, truncated and saturated.
// One quotient bit per cycle; no package dependency.
module asst_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [33:0] den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int NW = 64 + FRAC_BITS;
	localparam int HW = NW - 32;

	logic        busy_q, done_q, neg_q, ovf_q;
	logic [4:0]  cnt_q;
	logic [32:0] d_q, rem_q;
	logic [31:0] lo_q, q_q;
	logic signed [31:0] quo_q;
	logic [63:0] n_abs;
	logic [32:0] d_abs;
	logic [NW-1:0] n_sh;
	logic [33:0] t, t_sub;
	logic        t_ge;
	logic [31:0] q_nxt, lim, mag;

	// Magnitudes and the high part that sets overflow.
	always_comb begin
		n_abs = num[63] ? 64'(-num) : 64'(num);
		d_abs = den[33] ? 33'(-den) : 33'(den);
		n_sh = {n_abs, {FRAC_BITS{1'b0}}};
	end

	// One restoring step.
	always_comb begin
		t = {rem_q, lo_q[31]};
		t_sub = t - {1'b0, d_q};
		t_ge = (t >= {1'b0, d_q});
		q_nxt = {q_q[30:0], t_ge};
		lim = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		if (ovf_q || (q_nxt > lim)) begin
			mag = lim;
		end else begin
			mag = q_nxt;
		end
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= d_abs;
			neg_q <= num[63] ^ den[33];
			ovf_q <= (n_sh[NW-1:32] >= HW'(d_abs));
			rem_q <= n_sh[32 +: 33];
			lo_q <= n_sh[31:0];
			q_q <= '0;
		end else if (busy_q) begin
			rem_q <= t_ge ? t_sub[32:0] : t[32:0];
			lo_q <= lo_q << 1;
			q_q <= q_nxt;
			if (cnt_q == 5'd31) begin
				quo_q <= neg_q ? -$signed(mag) : $signed(mag);
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

[rtl/core/asst_sqrt.sv]
// Square root unit: halves s or divides it by three (truncated), then a
// digit-by-digit root of m * 2^F. Uses root_req_t from asst_pkg.
module asst_sqrt
	import asst_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  root_req_t          req,
	input  logic signed [63:0] s,
	output logic               done,
	output logic signed [31:0] root
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV3  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_ROOT  = 2'd3;
	localparam logic [63:0] M_LIM = 64'd1 << (62 - FRAC_BITS);

	logic [1:0]  state_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [63:0] sh_q, m_q, m_sh;
	logic [1:0]  r3_q;
	logic [2:0]  t3;
	logic        q3;
	logic [61:0] v_q;
	logic [32:0] rem_q;
	logic [30:0] root_q;
	logic [34:0] t, trial;
	logic        t_ge;
	logic signed [31:0] res_q;

	// Divide-by-three step and root step.
	always_comb begin
		t3 = {r3_q, sh_q[63]};
		q3 = (t3 >= 3'd3);
		t = {rem_q, v_q[61:60]};
		trial = {2'b00, root_q, 2'b01};
		t_ge = (t >= trial);
		m_sh = m_q << FRAC_BITS;
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= req.third ? ST_DIV3 : ST_CHECK;
						cnt_q <= '0;
					end
				end
				ST_DIV3: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (m_q >= M_LIM) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd30) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sh_q <= s;
				r3_q <= '0;
				m_q <= {1'b0, s[63:1]};
			end
			ST_DIV3: begin
				r3_q <= q3 ? 2'(t3 - 3'd3) : t3[1:0];
				m_q <= {m_q[62:0], q3};
				sh_q <= sh_q << 1;
			end
			ST_CHECK: begin
				v_q <= m_sh[61:0];
				rem_q <= '0;
				root_q <= '0;
				res_q <= 32'sh7FFF_FFFF;
			end
			ST_ROOT: begin
				v_q <= v_q << 2;
				if (t_ge) begin
					rem_q <= 33'(t - trial);
					root_q <= {root_q[29:0], 1'b1};
				end else begin
					rem_q <= t[32:0];
					root_q <= {root_q[29:0], 1'b0};
				end
				if (cnt_q == 6'd30) begin
					res_q <= {1'b0, root_q[29:0], t_ge};
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign root = res_q;

endmodule

[rtl/core/anchor_self_trilateration.sv]
// Top level of the anchor self-survey block: sequencer, stored anchor coordinates
// and output register. Depends on asst_pkg, asst_mul, asst_div and asst_sqrt.
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------------
//  in      | s_tvalid/s_tready | s_tuser kind, s_tdata six distances
//  out     | m_tvalid/m_tready | m_tdata pos_x,pos_y,pos_z, m_tuser flags
//  config  | cfg_we            | cfg_wdata floor value
//
// Anchor 1, errors and ignored kinds go from the accept straight to ST_OUT.
// Anchor 2 and anchor 3 run their micro-program on the bit-serial multiplier,
// divider and root units, used one after another. One item is worked on at a
// time; a new word is taken once the result has moved to the output register.
// Reset clears stored coordinates and the floor value goes to 6554.
module anchor_self_trilateration
	import asst_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // dist_ref0_to_target, dist_target_to_ref0,
	                               // dist_ref1_to_target, dist_target_to_ref1,
	                               // dist_ref2_to_target, dist_target_to_ref2
	input  logic [7:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // pos_x, pos_y, pos_z
	output logic [1:0]   m_tuser,  // computed, div_error
	input  logic         cfg_we,
	input  logic [16:0]  cfg_wdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]  state_q;
	logic [3:0]  step_q;
	logic        k3_q, done_q, err_q, m_tvalid_q;
	logic [16:0] floor_q;
	logic signed [31:0] x1_q, x2_q, y2_q;
	logic signed [31:0] r0_q, r1_q, r2_q, x_q, y_q, z_q;
	logic signed [ACC_W-1:0] accn_q, accs_q;
	logic [95:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic signed [31:0] avg0, avg1, avg2, op_a, op_b, quo, root_res;
	logic signed [32:0] x2_sum;
	logic signed [31:0] x2_sat;
	logic signed [ACC_W-1:0] prod;
	logic signed [33:0] den;
	logic        mul_start, div_start, mul_done, div_done, root_done, unit_done;
	logic        accept, s_pos;
	root_req_t   root_req;
	uop_t        uop;

	// Averages of each distance pair.
	function automatic logic signed [31:0] avg(logic [31:0] a, logic [31:0] b);
		logic signed [32:0] sum;
		sum = $signed({a[31], a}) + $signed({b[31], b});
		return sum[32:1];
	endfunction

	function automatic logic signed [31:0] pick(logic [2:0] sel,
			logic signed [31:0] r0, logic signed [31:0] r1, logic signed [31:0] r2,
			logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] x1,
			logic signed [31:0] x2, logic signed [31:0] y2);
		logic signed [31:0] v;
		unique case (sel)
			SEL_R0: v = r0;
			SEL_R1: v = r1;
			SEL_R2: v = r2;
			SEL_X:  v = x;
			SEL_Y:  v = y;
			SEL_X1: v = x1;
			SEL_X2: v = x2;
			default: v = y2;
		endcase
		return v;
	endfunction

	assign avg0 = avg(s_tdata[31:0], s_tdata[63:32]);
	assign avg1 = avg(s_tdata[95:64], s_tdata[127:96]);
	assign avg2 = avg(s_tdata[159:128], s_tdata[191:160]);

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// Current micro-operation and unit requests.
	always_comb begin
		uop = prog(k3_q, step_q);
		op_a = pick(uop.sel_a, r0_q, r1_q, r2_q, x_q, y_q, x1_q, x2_q, y2_q);
		op_b = pick(uop.sel_b, r0_q, r1_q, r2_q, x_q, y_q, x1_q, x2_q, y2_q);
		if (uop.op == OP_DIVY) begin
			den = -$signed({y2_q[31], y2_q, 1'b0});
		end else begin
			den = -$signed({x1_q[31], x1_q, 1'b0});
		end
		s_pos = (accs_q > 0);
		mul_start = (state_q == ST_ISSUE) && (uop.op == OP_MUL);
		div_start = (state_q == ST_ISSUE) && ((uop.op == OP_DIVX) || (uop.op == OP_DIVY));
		root_req.start = (state_q == ST_ISSUE) && (uop.op == OP_ROOT) && s_pos;
		root_req.third = k3_q;
		unique case (uop.op)
			OP_MUL: unit_done = mul_done;
			OP_DIVX, OP_DIVY: unit_done = div_done;
			OP_ROOT: unit_done = root_done;
			default: unit_done = 1'b0;
		endcase
		// Anchor 2 x adds half of anchor 1 x and saturates.
		x2_sum = $signed({quo[31], quo}) + $signed({x1_q[31], x1_q[31], x1_q[31:1]});
		if (x2_sum > 33'sd2147483647) begin
			x2_sat = 32'sh7FFF_FFFF;
		end else if (x2_sum < -33'sd2147483648) begin
			x2_sat = 32'sh8000_0000;
		end else begin
			x2_sat = x2_sum[31:0];
		end
	end

	asst_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(op_a), .b(op_b),
		.done(mul_done), .prod(prod)
	);

	asst_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(accn_q), .den(den),
		.done(div_done), .quo(quo)
	);

	asst_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .req(root_req), .s(accs_q),
		.done(root_done), .root(root_res)
	);

	// Sequencer, stored coordinates and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			m_tvalid_q <= 1'b0;
			floor_q <= 17'd6554;
			x1_q <= '0;
			x2_q <= '0;
			y2_q <= '0;
		end else begin
			if (cfg_we) begin
				floor_q <= cfg_wdata;
			end
			// The output word is loaded from ST_OUT and cleared once taken.
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if ((s_tuser == KIND_A2 && x1_q != 0)
								|| (s_tuser == KIND_A3 && x1_q != 0 && y2_q != 0)) begin
							state_q <= ST_ISSUE;
						end else begin
							state_q <= ST_OUT;
						end
						if (s_tuser == KIND_A1) begin
							x1_q <= avg0;
						end
					end
				end
				ST_ISSUE: begin
					if (uop.op == OP_END) begin
						state_q <= ST_OUT;
						if (!k3_q) begin
							x2_q <= x_q;
							y2_q <= y_q;
						end
					end else if (uop.op == OP_ROOT && !s_pos) begin
						step_q <= step_q + 4'd1;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (unit_done) begin
						state_q <= ST_ISSUE;
						step_q <= step_q + 4'd1;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers and output word.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				r0_q <= avg0;
				r1_q <= avg1;
				r2_q <= avg2;
				k3_q <= (s_tuser == KIND_A3);
				accn_q <= '0;
				accs_q <= '0;
				x_q <= (s_tuser == KIND_A1) ? avg0 : '0;
				y_q <= '0;
				z_q <= '0;
				done_q <= (s_tuser == KIND_A1);
				err_q <= (s_tuser == KIND_A2 && x1_q == 0)
					|| (s_tuser == KIND_A3 && (x1_q == 0 || y2_q == 0));
			end
			ST_ISSUE: begin
				if (uop.op == OP_END) begin
					done_q <= 1'b1;
				end else if (uop.op == OP_ROOT && !s_pos) begin
					if (k3_q) begin
						z_q <= 32'(floor_q);
					end else begin
						y_q <= 32'(floor_q);
					end
				end
			end
			ST_WAIT: begin
				if (unit_done) begin
					unique case (uop.op)
						OP_MUL: begin
							accn_q <= accn_q + scale(prod, uop.coef_n);
							accs_q <= accs_q + scale(prod, uop.coef_s);
						end
						OP_DIVX: begin
							x_q <= k3_q ? quo : x2_sat;
							accn_q <= '0;
						end
						OP_DIVY: begin
							y_q <= quo;
							accn_q <= '0;
						end
						default: begin
							if (k3_q) begin
								z_q <= root_res;
							end else begin
								y_q <= root_res;
							end
						end
					endcase
				end
			end
			default: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {z_q, y_q, x_q};
					m_tuser_q <= {err_q, done_q};
				end
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

[rtl/core/asst_chk.sv]
// Port-level checker for anchor_self_trilateration, bound to the top level.
// Depends only on the top level's ports.
module asst_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A word never reports both computed and an error.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("computed and div_error both set");

	// A word that was not computed carries a zero position.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 96'd0))
		else $error("uncomputed word has nonzero position");

	// One item at a time: input closes right after an accept.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted twice in a row");

	// A stalled output word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output word changed");

endmodule

bind anchor_self_trilateration asst_chk u_asst_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

[sim/anchor_self_trilateration_tb.sv]
// Testbench for anchor_self_trilateration: random and directed survey words,
// checked against an in-bench fixed-point predictor. Depends on asst_pkg and the RTL.
`timescale 1ns / 100ps

module anchor_self_trilateration_tb;
	import asst_pkg::*;

	localparam int FRAC = 16;
	localparam int SETTLE_CYCLES = 1000;

	typedef struct {
		logic [7:0]   kind;
		logic [191:0] dists;
	} survey_word_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        done;
		logic        err;
	} position_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic [7:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we;
	logic [16:0]  cfg_wdata;

	survey_word_t pending_words[$];
	position_t    expected_pos[$];
	int unsigned  cycle_cnt;
	int unsigned  results_seen;
	int unsigned  hold_cnt;
	bit           hold_done;
	bit           failed;

	// Predictor copy of the stored anchor coordinates and the floor register.
	logic signed [63:0] pred_x1, pred_x2, pred_y2;
	logic [16:0]        pred_floor;

	anchor_self_trilateration uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic signed [63:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [63:0] qmul(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p >>> FRAC;
	endfunction

	// Quotient truncated toward zero and saturated to 32 bits.
	function automatic logic signed [63:0] qdiv(logic signed [63:0] num,
			logic signed [63:0] den);
		logic        neg;
		logic [63:0] n, d, lim, q, r, mag;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? 64'd0 - num : num;
		d = (den < 0) ? 64'd0 - den : den;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		q = n / d;
		r = n % d;
		if (q > (lim >> FRAC))
			mag = lim;
		else
			mag = (q << FRAC) + ((r << FRAC) / d);
		if (mag > lim)
			mag = lim;
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [63:0] qsqrt(logic signed [63:0] m);
		logic [63:0] v, res, b;
		if ($unsigned(m) >= (64'd1 << (62 - FRAC)))
			return 64'sd2147483647;
		v = $unsigned(m) << FRAC;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return $signed(res);
	endfunction

	function automatic logic signed [63:0] range_of(logic [31:0] a, logic [31:0] b);
		logic signed [63:0] sum;
		sum = 64'($signed(a)) + 64'($signed(b));
		return sum >>> 1;
	endfunction

	// Places one anchor and updates the stored coordinates as the block does.
	function automatic position_t place_anchor(survey_word_t w);
		position_t          p;
		logic signed [63:0] r0, r1, r2, x, y, z, s;
		r0 = range_of(w.dists[31:0], w.dists[63:32]);
		r1 = range_of(w.dists[95:64], w.dists[127:96]);
		r2 = range_of(w.dists[159:128], w.dists[191:160]);
		x = 0;
		y = 0;
		z = 0;
		p.done = 1'b0;
		p.err = 1'b0;
		if (w.kind == KIND_A1) begin
			x = r0;
			pred_x1 = x;
			p.done = 1'b1;
		end else if (w.kind == KIND_A2) begin
			if (pred_x1 == 0) begin
				p.err = 1'b1;
			end else begin
				x = sat32(qdiv(qmul(r1, r1) - qmul(r0, r0), -2 * pred_x1)
					+ (pred_x1 >>> 1));
				s = qmul(r0, r0) + qmul(r1, r1) - 2 * qmul(x, x)
					+ 2 * qmul(x, pred_x1) - qmul(pred_x1, pred_x1);
				y = (s > 0) ? qsqrt(s >>> 1) : 64'(pred_floor);
				pred_x2 = x;
				pred_y2 = y;
				p.done = 1'b1;
			end
		end else if (w.kind == KIND_A3) begin
			if (pred_x1 == 0 || pred_y2 == 0) begin
				p.err = 1'b1;
			end else begin
				x = qdiv(qmul(r1, r1) - qmul(r0, r0) - qmul(pred_x1, pred_x1),
					-2 * pred_x1);
				y = qdiv(qmul(r2, r2) - qmul(r0, r0) - qmul(pred_y2, pred_y2)
					- qmul(pred_x2, pred_x2) + 2 * qmul(pred_x2, x), -2 * pred_y2);
				s = qmul(r0, r0) + qmul(r1, r1) + qmul(r2, r2)
					+ 2 * qmul(pred_x1, x) - qmul(pred_x1, pred_x1)
					+ 2 * qmul(pred_x2, x) - qmul(pred_x2, pred_x2)
					+ 2 * qmul(pred_y2, y) - qmul(pred_y2, pred_y2)
					- 3 * qmul(x, x) - 3 * qmul(y, y);
				z = (s > 0) ? qsqrt(s / 3) : 64'(pred_floor);
				p.done = 1'b1;
			end
		end
		p.x = x[31:0];
		p.y = y[31:0];
		p.z = z[31:0];
		return p;
	endfunction

	// Idling is off for a long stretch in the middle of the run.
	function automatic bit idle_now();
		if (cycle_cnt > 40000 && cycle_cnt < 90000)
			return 1'b0;
		return $urandom_range(0, 99) < 31;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cycle_cnt <= 0;
		else
			cycle_cnt <= cycle_cnt + 1;
	end

	// Driver: predicts each accepted word, then offers the next pending one.
	always @(posedge clk or negedge arst_n) begin
		survey_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				w.kind = s_tuser;
				w.dists = s_tdata;
				expected_pos.push_back(place_anchor(w));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() > 0 && !idle_now()) begin
					w = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= w.kind;
					s_tdata <= w.dists;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result and drives the receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		position_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_pos.size() == 0) begin
					$display("%0t: result with nothing expected: %h %b", $time,
						m_tdata, m_tuser);
					failed = 1'b1;
				end else begin
					e = expected_pos.pop_front();
					if (m_tdata[31:0] !== e.x) begin
						$display("%0t: pos_x expected %h actual %h", $time, e.x,
							m_tdata[31:0]);
						failed = 1'b1;
					end
					if (m_tdata[63:32] !== e.y) begin
						$display("%0t: pos_y expected %h actual %h", $time, e.y,
							m_tdata[63:32]);
						failed = 1'b1;
					end
					if (m_tdata[95:64] !== e.z) begin
						$display("%0t: pos_z expected %h actual %h", $time, e.z,
							m_tdata[95:64]);
						failed = 1'b1;
					end
					if (m_tuser[0] !== e.done) begin
						$display("%0t: computed expected %b actual %b", $time, e.done,
							m_tuser[0]);
						failed = 1'b1;
					end
					if (m_tuser[1] !== e.err) begin
						$display("%0t: div_error expected %b actual %b", $time, e.err,
							m_tuser[1]);
						failed = 1'b1;
					end
				end
			end
			// One long hold-off while the sender keeps offering words.
			if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= (hold_cnt == 1);
			end else if (!hold_done && results_seen == 300) begin
				hold_done <= 1'b1;
				hold_cnt <= 3000;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !idle_now();
			end
		end
	end

	function automatic logic [31:0] near(logic [31:0] base);
		return base + $urandom_range(0, 4000) - 2000;
	endfunction

	function automatic survey_word_t survey_word(logic [7:0] kind, logic [31:0] r0,
			logic [31:0] r1, logic [31:0] r2);
		survey_word_t w;
		w.kind = kind;
		w.dists = {near(r2), near(r2), near(r1), near(r1), near(r0), near(r0)};
		return w;
	endfunction

	function automatic logic [31:0] metres();
		return $urandom_range(0, 60 << FRAC);
	endfunction

	task automatic queue_word(logic [7:0] kind, logic [191:0] dists);
		survey_word_t w;
		w.kind = kind;
		w.dists = dists;
		pending_words.push_back(w);
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || expected_pos.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_floor(logic [16:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		pred_floor = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly full surveys (anchor 1, 2, then some anchor 3) plus noise words.
	task automatic queue_random(int unsigned count);
		int unsigned n;
		int          k;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 99) < 70) begin
				pending_words.push_back(survey_word(KIND_A1, metres(), metres(), metres()));
				pending_words.push_back(survey_word(KIND_A2, metres(), metres(), metres()));
				k = $urandom_range(1, 4);
				repeat (k)
					pending_words.push_back(survey_word(KIND_A3, metres(), metres(),
						metres()));
				n = n + 2 + k;
			end else begin
				queue_word($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(1, 3)),
					{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom()});
				n = n + 1;
			end
		end
	endtask

	initial begin
		failed = 1'b0;
		pred_x1 = 0;
		pred_x2 = 0;
		pred_y2 = 0;
		pred_floor = 17'd6554;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: errors before any anchor is stored, ignored kinds, extremes.
		queue_word(KIND_A2, {6{32'h0001_0000}});
		queue_word(KIND_A3, {6{32'h0001_0000}});
		queue_word(8'd0, '0);
		queue_word(8'd255, {6{32'hFFFF_FFFF}});
		queue_word(8'd4, {6{32'h7FFF_FFFF}});
		queue_word(KIND_A1, {6{32'h7FFF_FFFF}});
		queue_word(KIND_A2, {6{32'h8000_0000}});
		queue_word(KIND_A3, {6{32'h7FFF_FFFF}});
		queue_word(KIND_A1, {6{32'h8000_0000}});
		queue_word(KIND_A2, {6{32'h7FFF_FFFF}});
		queue_word(KIND_A3, {6{32'h8000_0000}});
		queue_word(KIND_A1, {128'd0, 32'h0000_0001, 32'hFFFF_FFFF});
		queue_word(KIND_A3, {6{32'h0002_0000}});
		pending_words.push_back(survey_word(KIND_A1, 10 << FRAC, 0, 0));
		pending_words.push_back(survey_word(KIND_A2, 6 << FRAC, 8 << FRAC, 0));
		pending_words.push_back(survey_word(KIND_A3, 5 << FRAC, 7 << FRAC, 6 << FRAC));
		pending_words.push_back(survey_word(KIND_A2, 1 << FRAC, 40 << FRAC, 0));
		pending_words.push_back(survey_word(KIND_A3, 50 << FRAC, 1 << FRAC, 30 << FRAC));
		wait_idle();

		// A zero floor lets anchor 2 store y = 0, so anchor 3 must flag it.
		write_floor(17'd0);
		pending_words.push_back(survey_word(KIND_A1, 10 << FRAC, 0, 0));
		pending_words.push_back(survey_word(KIND_A2, 1 << FRAC, 30 << FRAC, 0));
		pending_words.push_back(survey_word(KIND_A3, 5 << FRAC, 7 << FRAC, 6 << FRAC));
		queue_random(230);
		wait_idle();

		write_floor(17'd65536);
		queue_random(230);
		wait_idle();

		write_floor(17'($urandom_range(0, 65536)));
		queue_random(230);
		wait_idle();

		write_floor(17'd6554);
		queue_random(230);
		wait_idle();

		if (!failed)
			$display("anchor_self_trilateration_tb: PASS");
		else
			$display("anchor_self_trilateration_tb: FAIL");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("anchor_self_trilateration_tb: FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/asst_pkg.sv
rtl/core/asst_mul.sv
rtl/core/asst_div.sv
rtl/core/asst_sqrt.sv
rtl/core/anchor_self_trilateration.sv
rtl/core/asst_chk.sv
sim/anchor_self_trilateration_tb.sv
